// ===== src/radius_gated_point_dedup_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the point dedup table
// Shared property wrappers, sampled on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef RADIUS_GATED_POINT_DEDUP_TABLE_MACROS_SVH
`define RADIUS_GATED_POINT_DEDUP_TABLE_MACROS_SVH

// cons must hold in the same cycle as ante
`define RGPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define RGPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rgpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgpd_pkg
// Field widths, register indexes and the stored entry layout.
// ----------------------------------------------------------------------------
package rgpd_pkg;

    localparam int COORD_W   = 20;
    localparam int STAMP_W   = 48;
    localparam int ID_W      = 32;
    localparam int RADIUS_W  = 16;
    localparam int TIMEOUT_W = 27;
    localparam int R2_W      = 2 * RADIUS_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

    localparam logic [RADIUS_W-1:0]  RADIUS_RST  = 16'd3000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 27'd60000;

    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [STAMP_W-1:0]        stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // distance unit status toward the sequencer
    typedef struct packed {
        logic busy;
        logic vld;
        logic hit;
    } t_dist_stat;

endpackage

// ===== src/radius_gated_point_dedup_table.sv =====
// ----------------------------------------------------------------------------
// radius_gated_point_dedup_table
// Stores planar-distinct detections, ages them out and lists the table unless the point matched.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+---------------------
//  input   | i_x_mm i_y_mm i_z_mm i_stamp_ms           | start & !busy
//  result  | o_entry_id o_out_*_mm o_entry_valid ...   | o_strobe, 1 cycle
//  config  | i_cfg_idx i_cfg_wdata                     | i_cfg_we
//
// With N stored entries, a match scan makes N RAM reads that feed the 3-stage
// distance unit. A point with no match then gets one insert write, then a
// compaction pass reads every entry, writes kept entries down and emits them.
// A full table drops the point and runs only the compaction pass; a match ends
// with no pass and no list. The entry RAM has a single read port. The last beat
// is on the ports in the same cycle as busy drops. Reset is synchronous; the
// table starts empty with no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module radius_gated_point_dedup_table import rgpd_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_x_mm,
    input  logic signed [COORD_W-1:0] i_y_mm,
    input  logic signed [COORD_W-1:0] i_z_mm,
    input  logic [STAMP_W-1:0]        i_stamp_ms,
    output logic                      o_strobe,
    output logic [ID_W-1:0]           o_entry_id,
    output logic signed [COORD_W-1:0] o_out_x_mm,
    output logic signed [COORD_W-1:0] o_out_y_mm,
    output logic signed [COORD_W-1:0] o_out_z_mm,
    output logic                      o_entry_valid,
    output logic                      o_dropped,
    output logic                      o_last_item,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [TIMEOUT_W-1:0]      i_cfg_wdata
);

`include "radius_gated_point_dedup_table_macros.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_INSERT = 2'd2;
    localparam logic [1:0] S_CLEAN  = 2'd3;

    logic [1:0]           r_state;
    logic [CW-1:0]        r_count, r_idx, r_keep;
    logic [ID_W-1:0]      r_id_ctr;
    logic [RADIUS_W-1:0]  r_radius;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [R2_W-1:0]      r_r2;
    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic [STAMP_W-1:0]   r_now;
    logic                 r_rd_vld, r_hit, r_drop, r_pend_vld;
    t_entry               r_pend;

    logic                 r_o_strobe, r_o_valid, r_o_drop, r_o_last;
    t_entry               r_o_ent;

    t_entry               w_rdata, w_wdata;
    logic [ENTRY_W-1:0]   w_rdata_raw;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic                 w_issue;
    t_dist_stat           w_dist;
    logic [STAMP_W:0]     w_age;
    logic                 w_expired, w_kept;
    logic                 w_scan_done;

    assign busy = (r_state != S_IDLE);

    // --- entry store ---------------------------------------------------------
    assign w_issue = (r_state == S_MATCH || r_state == S_CLEAN) && (r_idx < r_count);
    assign w_rdata = t_entry'(w_rdata_raw);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_keep[AW-1:0];
        w_wdata = w_rdata;
        if (r_state == S_INSERT) begin
            w_we    = 1'b1;
            w_waddr = r_count[AW-1:0];
            w_wdata = '{id: r_id_ctr, x: r_px, y: r_py, z: r_pz, stamp: r_now};
        end else if (r_state == S_CLEAN) begin
            w_we = w_kept;
        end
    end

    rgpd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata_raw)
    );

    rgpd_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld && r_state == S_MATCH),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_ex    (w_rdata.x),
        .i_ey    (w_rdata.y),
        .i_r2    (r_r2),
        .o_stat  (w_dist)
    );

    // a stamp ahead of now never expires
    assign w_age     = {1'b0, r_now} - {1'b0, w_rdata.stamp};
    assign w_expired = !w_age[STAMP_W] &&
                       (w_age[STAMP_W-1:0] > {{(STAMP_W-TIMEOUT_W){1'b0}}, r_timeout});
    assign w_kept    = (r_state == S_CLEAN) && r_rd_vld && !w_expired;

    assign w_scan_done = (r_idx == r_count) && !r_rd_vld;

    always_ff @(posedge i_clk) begin
        r_r2 <= r_radius * r_radius;
    end

    // --- sequencer -----------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_id_ctr   <= '0;
            r_radius   <= RADIUS_RST;
            r_timeout  <= TIMEOUT_RST;
            r_idx      <= '0;
            r_keep     <= '0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_drop     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_o_strobe <= 1'b0;
        end else begin
            // a held kept entry goes out when the next one arrives, the last at scan end
            r_o_strobe <= (w_kept && r_pend_vld) || (r_state == S_CLEAN && w_scan_done);

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS:  r_radius  <= i_cfg_wdata[RADIUS_W-1:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_wdata;
                    default: ;
                endcase
            end

            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    if (w_dist.vld && w_dist.hit) begin
                        r_hit <= 1'b1;
                    end
                    if (w_scan_done && !w_dist.busy && !w_dist.vld) begin
                        r_idx      <= '0;
                        r_keep     <= '0;
                        r_pend_vld <= 1'b0;
                        r_drop     <= (r_count == CAP);
                        if (r_hit) begin
                            r_state <= S_IDLE;
                        end else if (r_count < CAP) begin
                            r_state <= S_INSERT;
                        end else begin
                            r_state <= S_CLEAN;
                        end
                    end
                end
                S_INSERT: begin
                    r_count  <= r_count + 1'b1;
                    r_id_ctr <= r_id_ctr + 1'b1;
                    r_state  <= S_CLEAN;
                end
                S_CLEAN: begin
                    // one kept entry is held back so the final one can be marked last
                    if (w_kept) begin
                        r_keep     <= r_keep + 1'b1;
                        r_pend_vld <= 1'b1;
                    end
                    if (w_scan_done) begin
                        r_count <= r_keep;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // --- payload -------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_px  <= i_x_mm;
            r_py  <= i_y_mm;
            r_pz  <= i_z_mm;
            r_now <= i_stamp_ms;
        end
        if (w_kept) begin
            r_pend <= w_rdata;
        end
        if (r_state == S_CLEAN) begin
            r_o_drop <= r_drop;
            if (w_kept) begin
                r_o_ent   <= r_pend;
                r_o_valid <= 1'b1;
                r_o_last  <= 1'b0;
            end
            if (w_scan_done) begin
                r_o_ent   <= r_pend_vld ? r_pend : '0;
                r_o_valid <= r_pend_vld;
                r_o_last  <= 1'b1;
            end
        end
    end

    assign o_strobe      = r_o_strobe;
    assign o_entry_id    = r_o_ent.id;
    assign o_out_x_mm    = r_o_ent.x;
    assign o_out_y_mm    = r_o_ent.y;
    assign o_out_z_mm    = r_o_ent.z;
    assign o_entry_valid = r_o_valid;
    assign o_dropped     = r_o_drop;
    assign o_last_item   = r_o_last;

    // --- checks --------------------------------------------------------------
    `RGPD_ASSERT_NEXT(a_start_busy, start && !busy, busy,
        "accepted item did not make the block busy")
    `RGPD_ASSERT_NOW(a_mid_list_busy, o_strobe && !o_last_item, busy,
        "list ended without a last item")
    `RGPD_ASSERT_NOW(a_empty_is_last, o_strobe && !o_entry_valid, o_last_item,
        "empty list marker not marked last")
    `RGPD_ASSERT_NOW(a_keep_bound, r_state == S_CLEAN, r_keep <= r_idx && r_idx <= r_count,
        "compaction write index ran ahead of read index")

endmodule

// ===== src/rgpd_ram.sv =====
// ----------------------------------------------------------------------------
// rgpd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rgpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rgpd_dist.sv =====
// ----------------------------------------------------------------------------
// rgpd_dist
// Three-stage planar distance test: difference, square, sum and compare.
// ----------------------------------------------------------------------------
module rgpd_dist import rgpd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,
    input  logic signed [COORD_W-1:0] i_ex,
    input  logic signed [COORD_W-1:0] i_ey,
    input  logic [R2_W-1:0]           i_r2,
    output t_dist_stat                o_stat
);

    localparam int DW = COORD_W + 1;
    localparam int SW = 2 * COORD_W;

    logic                 r_v1, r_v2, r_v3, r_hit;
    logic signed [DW-1:0] r_dx, r_dy;
    logic [SW-1:0]        r_sqx, r_sqy;
    logic signed [2*DW-1:0] w_px2, w_py2;
    logic [SW:0]          w_sum;

    assign w_px2 = r_dx * r_dx;
    assign w_py2 = r_dy * r_dy;
    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_dx  <= {i_px[COORD_W-1], i_px} - {i_ex[COORD_W-1], i_ex};
        r_dy  <= {i_py[COORD_W-1], i_py} - {i_ey[COORD_W-1], i_ey};
        // |dx| < 2^20, so the square fits in 40 bits
        r_sqx <= w_px2[SW-1:0];
        r_sqy <= w_py2[SW-1:0];
        r_hit <= w_sum < {{(SW+1-R2_W){1'b0}}, i_r2};
    end

    assign o_stat.busy = r_v1 | r_v2;
    assign o_stat.vld  = r_v3;
    assign o_stat.hit  = r_hit;

endmodule
